// ----- rtl/sut_pkg.sv -----
// shared types, sizes and codes for the sorted unique table
// no dependencies
package sut_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  localparam int OP_W    = 2;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 5;
  localparam int STAT_W  = 3;
  localparam int CNT_OUT_W = 5;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_DELETED   = 3'd3;
  localparam logic [STAT_W-1:0] ST_BADPOS    = 3'd4;
  localparam logic [STAT_W-1:0] ST_READ      = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } item_t;

  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic signed [VALUE_W-1:0] read_value;
    logic [CNT_OUT_W-1:0]      entry_count;
  } result_t;

endpackage

// ----- rtl/sut_table.sv -----
// sorted entry array with parallel compare-and-shift insert, delete and read
// depends on sut_pkg
module sut_table (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            req_valid,
  input  sut_pkg::item_t  req,
  output sut_pkg::result_t res
);

  logic signed [sut_pkg::DATA_WIDTH-1:0] entries_r   [sut_pkg::CAPACITY];
  logic signed [sut_pkg::DATA_WIDTH-1:0] entries_nxt [sut_pkg::CAPACITY];
  logic [sut_pkg::CNT_W-1:0]             count_r;
  logic [sut_pkg::CNT_W-1:0]             count_nxt;

  logic signed [sut_pkg::DATA_WIDTH-1:0] key;
  logic [sut_pkg::CAPACITY-1:0]          lt;
  logic [sut_pkg::CAPACITY-1:0]          eq;
  logic                                  full;
  logic                                  pos_ok;
  logic [sut_pkg::POS_W-1:0]             pos_m1;
  logic [sut_pkg::IDX_W-1:0]             rd_idx;
  logic [sut_pkg::STAT_W-1:0]            status;
  logic signed [sut_pkg::VALUE_W-1:0]    read_val;

  assign key    = sut_pkg::DATA_WIDTH'(req.value);
  assign full   = (count_r == sut_pkg::CNT_W'(sut_pkg::CAPACITY));
  assign pos_m1 = req.position - sut_pkg::POS_W'(1);
  assign rd_idx = sut_pkg::IDX_W'(pos_m1);
  assign pos_ok = (req.position != '0) &&
                  (sut_pkg::CMP_W'(req.position) <= sut_pkg::CMP_W'(count_r));

  // per-entry compare, only live entries take part
  always_comb begin
    for (int i = 0; i < sut_pkg::CAPACITY; i++) begin
      lt[i] = (i < int'(count_r)) && (entries_r[i] < key);
      eq[i] = (i < int'(count_r)) && (entries_r[i] == key);
    end
  end

  always_comb begin
    entries_nxt = entries_r;
    count_nxt   = count_r;
    status      = sut_pkg::ST_BADPOS;
    read_val    = '0;
    unique case (req.op)
      sut_pkg::OP_INSERT: begin
        if (|eq) begin
          status = sut_pkg::ST_DUPLICATE;
        end else if (full) begin
          status = sut_pkg::ST_FULL;
        end else begin
          status    = sut_pkg::ST_INSERTED;
          count_nxt = count_r + sut_pkg::CNT_W'(1);
          if (!lt[0]) begin
            entries_nxt[0] = key;
          end
          for (int i = 1; i < sut_pkg::CAPACITY; i++) begin
            if (!lt[i]) begin
              entries_nxt[i] = lt[i-1] ? key : entries_r[i-1];
            end
          end
        end
      end
      sut_pkg::OP_DELETE: begin
        if (pos_ok) begin
          status    = sut_pkg::ST_DELETED;
          count_nxt = count_r - sut_pkg::CNT_W'(1);
          for (int i = 0; i < sut_pkg::CAPACITY - 1; i++) begin
            if (int'(req.position) <= i + 1) begin
              entries_nxt[i] = entries_r[i+1];
            end
          end
        end
      end
      sut_pkg::OP_READ: begin
        if (pos_ok) begin
          status   = sut_pkg::ST_READ;
          read_val = sut_pkg::VALUE_W'(entries_r[rd_idx]);
        end
      end
      default: begin
        status = sut_pkg::ST_BADPOS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      entries_r <= entries_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (req_valid) begin
      count_r <= count_nxt;
    end
  end

  assign res.status      = status;
  assign res.read_value  = read_val;
  assign res.entry_count = sut_pkg::CNT_OUT_W'(count_nxt);

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sut_pkg::CNT_W'(sut_pkg::CAPACITY))
    else $error("entry count beyond capacity");

  a_count_step : assert property (@(posedge clk) disable iff (!rst_n)
    !req_valid |=> $stable(count_r))
    else $error("entry count moved with no item");

  for (genvar g = 0; g < sut_pkg::CAPACITY - 1; g++) begin : g_order
    a_ascending : assert property (@(posedge clk) disable iff (!rst_n)
      (int'(count_r) > g + 1) |-> (entries_r[g] < entries_r[g+1]))
      else $error("table not strictly ascending");
  end

endmodule

// ----- rtl/sorted_unique_table.sv -----
// sorted unique table top level: input register, table update and result register
// one item per cycle; result strobed from the result register, behind the input register; busy stays low
// synchronous active-low reset empties the table; entry contents are not cleared
// depends on sut_pkg and sut_table
module sorted_unique_table (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  sut_pkg::item_t   in_item,
  output logic             out_valid,
  output sut_pkg::result_t out_result
);

  logic             in_valid_r;
  sut_pkg::item_t   in_item_r;
  logic             out_valid_r;
  sut_pkg::result_t out_result_r;
  sut_pkg::result_t res;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= start;
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    in_item_r    <= in_item;
    out_result_r <= res;
  end

  sut_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid_r),
    .req       (in_item_r),
    .res       (res)
  );

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  a_strobe_follows : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r |=> out_valid_r)
    else $error("item lost between stages");

  a_no_ghost : assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |=> !out_valid_r)
    else $error("result with no item");

  a_insert_count : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_result_r.status == sut_pkg::ST_INSERTED) |->
      (out_result_r.entry_count != '0))
    else $error("insert left table empty");

endmodule

// ----- test/sorted_unique_table_tb.sv -----
// self-checking testbench for sorted_unique_table: directed and random items against an
// in-bench table predictor; depends on sut_pkg and the sorted_unique_table rtl
`timescale 1ns / 1ps

module sorted_unique_table_tb;

  localparam logic [sut_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  sut_pkg::item_t   in_item;
  logic             out_valid;
  sut_pkg::result_t out_result;

  logic signed [sut_pkg::VALUE_W-1:0] table_vals [sut_pkg::CAPACITY];
  int                                 table_count;
  sut_pkg::result_t                   pending_results[$];
  int                                 mismatches;

  sorted_unique_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_result(out_result)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic sut_pkg::item_t mk_item(logic [sut_pkg::OP_W-1:0] op,
                                             logic [sut_pkg::VALUE_W-1:0] value,
                                             logic [sut_pkg::POS_W-1:0] position);
    sut_pkg::item_t it;
    it.op       = op;
    it.value    = value;
    it.position = position;
    return it;
  endfunction

  // updates the predicted table and returns the expected result
  function automatic sut_pkg::result_t apply_to_table(sut_pkg::item_t it);
    sut_pkg::result_t                   r;
    logic signed [sut_pkg::VALUE_W-1:0] v;
    int                                 slot;
    int                                 pos;
    int                                 i;
    r.status     = sut_pkg::ST_BADPOS;
    r.read_value = '0;
    v            = $signed(it.value);
    pos          = int'(it.position);
    case (it.op)
      sut_pkg::OP_INSERT: begin
        slot = 0;
        while (slot < table_count && table_vals[slot] < v) slot++;
        if (slot < table_count && table_vals[slot] == v) begin
          r.status = sut_pkg::ST_DUPLICATE;
        end else if (table_count >= sut_pkg::CAPACITY) begin
          r.status = sut_pkg::ST_FULL;
        end else begin
          for (i = table_count; i > slot; i--) table_vals[i] = table_vals[i-1];
          table_vals[slot] = v;
          table_count++;
          r.status = sut_pkg::ST_INSERTED;
        end
      end
      sut_pkg::OP_DELETE: begin
        if (pos != 0 && pos <= table_count) begin
          for (i = pos - 1; i + 1 < table_count; i++) table_vals[i] = table_vals[i+1];
          table_count--;
          r.status = sut_pkg::ST_DELETED;
        end
      end
      sut_pkg::OP_READ: begin
        if (pos != 0 && pos <= table_count) begin
          r.read_value = table_vals[pos-1];
          r.status     = sut_pkg::ST_READ;
        end
      end
      default: r.status = sut_pkg::ST_BADPOS;
    endcase
    r.entry_count = sut_pkg::CNT_OUT_W'(table_count);
    return r;
  endfunction

  task automatic send_item(sut_pkg::item_t it);
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_to_table(it));
  endtask

  task automatic idle_cycle();
    @(negedge clk);
    start   <= 1'b0;
    in_item <= mk_item(sut_pkg::OP_W'($urandom), $urandom, sut_pkg::POS_W'($urandom));
  endtask

  task automatic drain_results();
    idle_cycle();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    sut_pkg::result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d value %0d count %0d",
                   out_result.status, out_result.read_value, out_result.entry_count);
      end else begin
        want = pending_results.pop_front();
        if (out_result.status !== want.status || out_result.read_value !== want.read_value ||
            out_result.entry_count !== want.entry_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d value %0d count %0d, got %0d %0d %0d",
                     want.status, want.read_value, want.entry_count,
                     out_result.status, out_result.read_value, out_result.entry_count);
        end
      end
    end
  end

  task automatic test_empty_table();
    send_item(mk_item(sut_pkg::OP_READ, 32'h0, 5'd1));
    send_item(mk_item(sut_pkg::OP_DELETE, 32'hffff_ffff, 5'd0));
    send_item(mk_item(OP_UNUSED, 32'h1234_5678, 5'd31));
  endtask

  task automatic test_insert_extremes();
    send_item(mk_item(sut_pkg::OP_INSERT, 32'h7fff_ffff, 5'd0));
    send_item(mk_item(sut_pkg::OP_INSERT, 32'h8000_0000, 5'd31));
    send_item(mk_item(sut_pkg::OP_INSERT, 32'h0000_0000, 5'd0));
    send_item(mk_item(sut_pkg::OP_INSERT, 32'hffff_ffff, 5'd0));
    send_item(mk_item(sut_pkg::OP_INSERT, 32'h8000_0000, 5'd0));
  endtask

  task automatic test_full_table();
    int k;
    for (k = 1; k <= sut_pkg::CAPACITY - 4; k++)
      send_item(mk_item(sut_pkg::OP_INSERT, 32'(k * 1000 - 5000), 5'd0));
    send_item(mk_item(sut_pkg::OP_INSERT, 32'd77, 5'd0));
    send_item(mk_item(sut_pkg::OP_INSERT, 32'h7fff_ffff, 5'd0));
    send_item(mk_item(sut_pkg::OP_INSERT, 32'd78, 5'd0));
    send_item(mk_item(OP_UNUSED, 32'd77, 5'd1));
  endtask

  task automatic test_positions();
    send_item(mk_item(sut_pkg::OP_READ, 32'h0, 5'd16));
    send_item(mk_item(sut_pkg::OP_READ, 32'h0, 5'd17));
    send_item(mk_item(sut_pkg::OP_DELETE, 32'h0, 5'd1));
    send_item(mk_item(sut_pkg::OP_DELETE, 32'h0, 5'd31));
    send_item(mk_item(sut_pkg::OP_DELETE, 32'h0, 5'(table_count)));
    send_item(mk_item(sut_pkg::OP_READ, 32'h0, 5'd0));
    send_item(mk_item(sut_pkg::OP_READ, 32'h0, 5'd1));
  endtask

  task automatic test_random_traffic(int n_items, bit with_gaps);
    int                           k;
    int                           pick;
    logic [sut_pkg::OP_W-1:0]     op;
    logic [sut_pkg::VALUE_W-1:0]  value;
    logic [sut_pkg::POS_W-1:0]    position;
    for (k = 0; k < n_items; k++) begin
      pick = $urandom_range(99);
      // alternate fill-heavy and drain-heavy stretches so the table swings empty to full
      if ((k / 100) % 2 == 0)
        op = (pick < 62) ? sut_pkg::OP_INSERT : (pick < 77) ? sut_pkg::OP_DELETE :
             (pick < 95) ? sut_pkg::OP_READ : OP_UNUSED;
      else
        op = (pick < 30) ? sut_pkg::OP_INSERT : (pick < 75) ? sut_pkg::OP_DELETE :
             (pick < 95) ? sut_pkg::OP_READ : OP_UNUSED;
      pick = $urandom_range(99);
      if (pick < 50)
        value = 32'(int'($urandom_range(40)) - 20);
      else if (pick < 65)
        value = 32'h8000_0000 + $urandom_range(3);
      else if (pick < 75)
        value = 32'h7fff_ffff - $urandom_range(3);
      else
        value = $urandom;
      if ($urandom_range(99) < 80 && table_count > 0)
        position = sut_pkg::POS_W'($urandom_range(table_count, 1));
      else
        position = sut_pkg::POS_W'($urandom_range(31));
      if (with_gaps)
        while ($urandom_range(99) < 31) idle_cycle();
      send_item(mk_item(op, value, position));
    end
  endtask

  initial begin
    int w;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_item     = '0;
    table_count = 0;
    mismatches  = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_insert_extremes();
    test_full_table();
    test_positions();
    drain_results();
    test_random_traffic(400, 1'b0);
    drain_results();
    test_random_traffic(1200, 1'b1);
    idle_cycle();

    for (w = 0; w < 1000 && pending_results.size() != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sut_pkg.sv
rtl/sut_table.sv
rtl/sorted_unique_table.sv
test/sorted_unique_table_tb.sv
